[design/ct_pkg.sv]
package ct_pkg;

  // Byte words are fixed at eight characters.
  localparam int unsigned WordChars = 8;
  localparam int unsigned WordBits  = 8 * WordChars;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CHECK  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_EXISTS    = 3'd1,
    STS_FORMAT    = 3'd2,
    STS_FULL      = 3'd3,
    STS_NAME_LONG = 3'd4,
    STS_PASS_LONG = 3'd5,
    STS_NOT_FOUND = 3'd6
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start;       // latch the request, rewind the scan
    logic    scan_rd;     // read the next entry of the scan
    logic    append;      // write the request at the end, bump the count
    logic    remove_hit;  // remember the hit slot, drop the count
    logic    move_rd;     // read the last entry
    logic    move_wr;     // write the last entry into the hit slot
    logic    res_set;     // capture the result fields
    status_e res_status;
    logic    res_found;   // result index is the compared slot
    logic    res_check;   // result match is the password compare
    logic    out_load;    // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic len_zero;
    logic name_long;
    logic pass_long;
    logic name_ok;
    logic hit;
    logic last;
  } sts_t;

  // Clear every byte at or beyond len.
  function automatic logic [WordBits-1:0] keep_bytes(logic [WordBits-1:0] word,
                                                     logic [7:0] len);
    logic [WordBits-1:0] res;
    res = '0;
    for (int i = 0; i < WordChars; i++) begin
      if (len > 8'(i)) begin
        res[8*i +: 8] = word[8*i +: 8];
      end
    end
    return res;
  endfunction

endpackage

[design/ct_req_if.sv]
interface ct_req_if import ct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [WordBits-1:0] user_name;
  logic [7:0]          name_length;
  logic [WordBits-1:0] secret;
  logic [7:0]          secret_length;

  modport source (
    output valid, operation, user_name, name_length, secret, secret_length,
    input  ready
  );
  modport sink (
    input  valid, operation, user_name, name_length, secret, secret_length,
    output ready
  );
endinterface

[design/ct_rsp_if.sv]
interface ct_rsp_if import ct_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] entry_index;
  logic       matched;
  logic [4:0] entry_count;

  modport source (
    output valid, status, entry_index, matched, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, matched, entry_count,
    output ready
  );
endinterface

[design/ct_dp.sv]
module ct_dp import ct_pkg::*; #(
  parameter int unsigned MAX_ENTRIES  = 16,
  parameter int unsigned NAME_CHARS   = 8,
  parameter int unsigned SECRET_CHARS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [1:0]          operation_i,
  input  logic [WordBits-1:0] user_name_i,
  input  logic [7:0]          name_length_i,
  input  logic [WordBits-1:0] secret_i,
  input  logic [7:0]          secret_length_i,
  output logic [2:0]          status_o,
  output logic [3:0]          entry_index_o,
  output logic                matched_o,
  output logic [4:0]          entry_count_o
);

  localparam int unsigned NW = 8 * NAME_CHARS;
  localparam int unsigned SW = 8 * SECRET_CHARS;
  localparam int unsigned EW = NW + SW;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [WordBits-1:0] name_mask, sec_mask;
  logic [NW-1:0]       name_q;
  logic [SW-1:0]       sec_q;
  logic [7:0]          nlen_q, slen_q;
  op_e                 op_q;

  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q;
  logic [IW-1:0]       pidx_q, pos_q;
  logic                pend_q;
  logic                rd_go;

  logic [EW-1:0]       mem_q [MAX_ENTRIES];
  logic [EW-1:0]       rd_data_q;
  logic                mem_we;
  logic [IW-1:0]       mem_wa, mem_ra;
  logic [EW-1:0]       mem_wd;
  logic                mem_re;

  status_e             res_status_q;
  logic [IW-1:0]       res_idx_q;
  logic                res_matched_q;
  logic                secret_ok, sec_equal;

  logic [IW+3:0]       idx_ext;
  logic [CW+4:0]       cnt_ext;

  assign name_mask = keep_bytes(user_name_i, name_length_i);
  assign sec_mask  = keep_bytes(secret_i, secret_length_i);

  // Request latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= op_e'(operation_i);
      name_q <= name_mask[NW-1:0];
      sec_q  <= sec_mask[SW-1:0];
      nlen_q <= name_length_i;
      slen_q <= secret_length_i;
    end
  end

  assign rd_go = cmd_i.scan_rd && (idx_q != count_q);

  always_comb begin
    count_d = count_q;
    if (cmd_i.append) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.remove_hit) begin
      count_d = count_q - CW'(1);
    end
  end

  // Scan pointer and entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= rd_go;
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (rd_go) begin
        idx_q <= idx_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      pidx_q <= idx_q[IW-1:0];
    end
    if (cmd_i.remove_hit) begin
      pos_q <= pidx_q;
    end
  end

  // Entry memory: name in the high part, password in the low part.
  always_comb begin
    mem_we = cmd_i.append || cmd_i.move_wr;
    mem_wa = cmd_i.append ? count_q[IW-1:0] : pos_q;
    mem_wd = cmd_i.append ? {name_q, sec_q} : rd_data_q;
    mem_re = rd_go || cmd_i.move_rd;
    mem_ra = cmd_i.move_rd ? count_q[IW-1:0] : idx_q[IW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

  assign secret_ok = (slen_q != 8'd0) && (slen_q <= 8'(SECRET_CHARS));
  assign sec_equal = (rd_data_q[SW-1:0] == sec_q);

  always_comb begin
    sts_o.op        = op_q;
    sts_o.full      = (count_q == CW'(MAX_ENTRIES));
    sts_o.empty     = (count_q == '0);
    sts_o.len_zero  = (nlen_q == 8'd0) || (slen_q == 8'd0);
    sts_o.name_long = (nlen_q > 8'(NAME_CHARS));
    sts_o.pass_long = (slen_q > 8'(SECRET_CHARS));
    sts_o.name_ok   = (nlen_q != 8'd0) && (nlen_q <= 8'(NAME_CHARS));
    sts_o.hit       = pend_q && (rd_data_q[EW-1 -: NW] == name_q);
    sts_o.last      = pend_q && (CW'(pidx_q) == (count_q - CW'(1)));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_status_q  <= cmd_i.res_status;
      res_idx_q     <= cmd_i.res_found ? pidx_q : '0;
      res_matched_q <= cmd_i.res_check && secret_ok && sec_equal;
    end
  end

  assign idx_ext = {4'd0, res_idx_q};
  assign cnt_ext = {5'd0, count_q};

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o      <= res_status_q;
      entry_index_o <= idx_ext[3:0];
      matched_o     <= res_matched_q;
      entry_count_o <= cnt_ext[4:0];
    end
  end

endmodule

[design/ct_ctrl.sv]
module ct_ctrl import ct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_EVAL    = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_APPEND  = 7'b0001000,
    S_MOVE_RD = 7'b0010000,
    S_MOVE_WR = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !rsp_ready_i;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.res_set = 1'b1;
        state_d       = S_DONE;
        if (sts_i.op == OP_ADD) begin
          if (sts_i.full) begin
            cmd_o.res_status = STS_FULL;
          end else if (sts_i.len_zero) begin
            cmd_o.res_status = STS_FORMAT;
          end else if (sts_i.name_long) begin
            cmd_o.res_status = STS_NAME_LONG;
          end else if (sts_i.pass_long) begin
            cmd_o.res_status = STS_PASS_LONG;
          end else if (sts_i.empty) begin
            cmd_o.res_set = 1'b0;
            state_d       = S_APPEND;
          end else begin
            cmd_o.res_set = 1'b0;
            cmd_o.scan_rd = 1'b1;
            state_d       = S_SCAN;
          end
        end else if (!sts_i.name_ok || sts_i.empty) begin
          cmd_o.res_status = (sts_i.op == OP_CHECK) ? STS_OK : STS_NOT_FOUND;
        end else begin
          cmd_o.res_set = 1'b0;
          cmd_o.scan_rd = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.res_set = 1'b1;
          state_d       = S_DONE;
          case (sts_i.op)
            OP_ADD: cmd_o.res_status = STS_EXISTS;
            OP_REMOVE: begin
              cmd_o.remove_hit = 1'b1;
              state_d          = S_MOVE_RD;
            end
            OP_FIND:  cmd_o.res_found = 1'b1;
            OP_CHECK: cmd_o.res_check = 1'b1;
            default: ;
          endcase
        end else if (sts_i.last) begin
          if (sts_i.op == OP_ADD) begin
            state_d = S_APPEND;
          end else begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = (sts_i.op == OP_CHECK) ? STS_OK : STS_NOT_FOUND;
            state_d          = S_DONE;
          end
        end else begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      S_APPEND: begin
        cmd_o.append  = 1'b1;
        cmd_o.res_set = 1'b1;
        state_d       = S_DONE;
      end
      S_MOVE_RD: begin
        cmd_o.move_rd = 1'b1;
        state_d       = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd_o.move_wr = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[design/credential_table.sv]
// Sequence: an early reject goes from request transfer through evaluate to the output
//   register; a scan reads entries in order, and a remove hit adds a move read and write.
// Requests: one at a time; the next request is taken once the result is in the output
//   register, even while that result still waits for its transfer.
// Reset: clears the entry count, the controller and the output valid; the entry memory
//   is not cleared, since only entries below the count are ever read.
module credential_table import ct_pkg::*; #(
  parameter int unsigned MAX_ENTRIES  = 16,
  parameter int unsigned NAME_CHARS   = 8,
  parameter int unsigned SECRET_CHARS = 8
) (
  input logic      clk_i,
  input logic      rst_ni,
  ct_req_if.sink   req_i,
  ct_rsp_if.source rsp_o
);

  // Command and status between the sequencer and the table datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller walks one request through evaluate, scan, append or
  // swap-remove, and finally loads the output register.
  ct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the packed entry memory, the count, the scan
  // pointer with its registered memory read, and the result registers.
  ct_dp #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .NAME_CHARS   (NAME_CHARS),
    .SECRET_CHARS (SECRET_CHARS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (req_i.operation),
    .user_name_i     (req_i.user_name),
    .name_length_i   (req_i.name_length),
    .secret_i        (req_i.secret),
    .secret_length_i (req_i.secret_length),
    .status_o        (rsp_o.status),
    .entry_index_o   (rsp_o.entry_index),
    .matched_o       (rsp_o.matched),
    .entry_count_o   (rsp_o.entry_count)
  );

endmodule
